// ===== rtl/rbsd_pkg.sv =====
// Shared types and constants for the run-length byte stream decoder.
package rbsd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned BCNT_W = 2;

  // Header bit 7 selects a literal header, the low seven bits carry the count.
  localparam int unsigned HDR_LIT_BIT = 7;

  localparam logic [BCNT_W-1:0] BCNT_ONE = 2'd1;
  localparam logic [BCNT_W-1:0] BCNT_TWO = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BCNT_W-1:0] byte_count;
    logic              out_last;
  } out_t;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_RUN,
    ST_LIT,
    ST_EXPAND
  } state_t;

  typedef struct packed {
    logic load_rem;
    logic dec_rem;
    logic load_run;
    logic emit_lit;
    logic emit_run;
  } cmd_t;

  typedef struct packed {
    logic hdr_is_lit;
    logic hdr_cnt_zero;
    logic rem_zero;
    logic rem_one;
    logic rem_le2;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/rbsd_ctrl.sv =====
// Controller state machine: stream phase and run expansion sequencing.
module rbsd_ctrl import rbsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r != ST_EXPAND) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HEADER: begin
        if (accept) begin
          if (in_last) begin
            state_nxt = ST_HEADER;
          end else if (!stat.hdr_is_lit) begin
            state_nxt = ST_RUN;
          end else if (stat.hdr_cnt_zero) begin
            state_nxt = ST_HEADER;
          end else begin
            state_nxt = ST_LIT;
          end
        end
      end
      ST_RUN: begin
        if (accept) begin
          state_nxt = stat.rem_zero ? ST_HEADER : ST_EXPAND;
        end
      end
      ST_LIT: begin
        if (accept && (in_last || stat.rem_one)) begin
          state_nxt = ST_HEADER;
        end
      end
      ST_EXPAND: begin
        // Leave once the final result of the run is emitted.
        if (stat.out_free && stat.rem_le2) begin
          state_nxt = ST_HEADER;
        end
      end
      default: state_nxt = ST_HEADER;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_HEADER: cmd.load_rem = accept;
      ST_RUN:    cmd.load_run = accept;
      ST_LIT: begin
        cmd.emit_lit = accept;
        cmd.dec_rem  = accept;
      end
      ST_EXPAND: cmd.emit_run = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ===== rtl/rbsd_dp.sv =====
// Datapath: count register, held run byte and the result register.
module rbsd_dp import rbsd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [BYTE_W-1:0] run_byte_r;
  logic [BYTE_W-1:0] run_byte_nxt;
  out_t              out_r;
  out_t              out_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              rem_ge2;

  assign rem_ge2 = (rem_r[CNT_W-1:1] != '0);

  assign stat.hdr_is_lit   = in_data.in_byte[HDR_LIT_BIT];
  assign stat.hdr_cnt_zero = (in_data.in_byte[CNT_W-1:0] == '0);
  assign stat.rem_zero     = (rem_r == '0);
  assign stat.rem_one      = (rem_r == CNT_W'(1));
  assign stat.rem_le2      = !rem_ge2 || (rem_r == CNT_W'(2));
  assign stat.out_free     = !out_valid_r || out_ready;

  always_comb begin
    rem_nxt      = rem_r;
    run_byte_nxt = run_byte_r;
    if (cmd.load_rem) begin
      rem_nxt = in_data.in_byte[CNT_W-1:0];
    end else if (cmd.dec_rem) begin
      rem_nxt = rem_r - CNT_W'(1);
    end else if (cmd.emit_run) begin
      rem_nxt = rem_ge2 ? (rem_r - CNT_W'(2)) : (rem_r - CNT_W'(1));
    end
    if (cmd.load_run) begin
      run_byte_nxt = in_data.in_byte;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_lit) begin
      out_nxt.first_byte  = in_data.in_byte;
      out_nxt.second_byte = '0;
      out_nxt.byte_count  = BCNT_ONE;
      out_nxt.out_last    = 1'b1;
      out_valid_nxt       = 1'b1;
    end else if (cmd.emit_run) begin
      out_nxt.first_byte  = run_byte_r;
      out_nxt.second_byte = rem_ge2 ? run_byte_r : '0;
      out_nxt.byte_count  = rem_ge2 ? BCNT_TWO : BCNT_ONE;
      out_nxt.out_last    = stat.rem_le2;
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    run_byte_r <= run_byte_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_lit && cmd.emit_run))
    else $error("literal and run results emitted together");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_lit || cmd.emit_run) |-> stat.out_free)
    else $error("result emitted over an untaken result");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_run |-> !stat.rem_zero)
    else $error("run result emitted with no bytes left");

  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_run && stat.rem_le2) |=> (out_valid_r && out_r.out_last))
    else $error("final run result not marked last");
`endif

endmodule

// ===== rtl/rle_byte_stream_decoder.sv =====
// Run-length byte stream decoder, top level. A header with bit 7 clear
// repeats the next byte count times, a header with bit 7 set copies the next
// count bytes; decoded bytes leave packed up to two per result. Header and
// literal bytes are taken one per cycle. A run byte holds the input until its
// expansion is done: the run expansion drives the single output register with
// one result per cycle, unless the result register stalls, while the input is
// held off. A stalled result register holds off further input. in_last returns
// the decoder to expecting a header after its byte is handled.
module rle_byte_stream_decoder import rbsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  rbsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.in_last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbsd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
